FILE: rtl/nec_ir_pkg.sv
// Shared types, constants and helpers for the NEC infrared edge-interval decoder.
// No dependencies; imported by every module of the block.
package nec_ir_pkg;

  localparam int unsigned TIME_W    = 16;
  localparam int unsigned IR_CODE_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER_MIN = 3'd0,
    CFG_LEADER_MAX = 3'd1,
    CFG_ZERO_MIN   = 3'd2,
    CFG_ZERO_MAX   = 3'd3,
    CFG_ONE_MIN    = 3'd4,
    CFG_ONE_MAX    = 3'd5
  } cfg_index_t;

  localparam logic [TIME_W-1:0] LEADER_MIN_RST = 16'd13000;
  localparam logic [TIME_W-1:0] LEADER_MAX_RST = 16'd14000;
  localparam logic [TIME_W-1:0] ZERO_MIN_RST   = 16'd1000;
  localparam logic [TIME_W-1:0] ZERO_MAX_RST   = 16'd1200;
  localparam logic [TIME_W-1:0] ONE_MIN_RST    = 16'd2100;
  localparam logic [TIME_W-1:0] ONE_MAX_RST    = 16'd2350;

  // Interval windows, all inclusive
  typedef struct packed {
    logic [TIME_W-1:0] leader_min;
    logic [TIME_W-1:0] leader_max;
    logic [TIME_W-1:0] zero_min;
    logic [TIME_W-1:0] zero_max;
    logic [TIME_W-1:0] one_min;
    logic [TIME_W-1:0] one_max;
  } windows_t;

  // Result of decoding the edge held in the input stage
  typedef struct packed {
    logic                 done;
    logic [IR_CODE_W-1:0] code;
  } frame_result_t;

  function automatic logic in_window(input logic [TIME_W-1:0] v,
                                     input logic [TIME_W-1:0] lo,
                                     input logic [TIME_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

FILE: rtl/nec_ir_cfg_regs.sv
// Configuration register file holding the six bounds of the three interval windows.
// Depends on nec_ir_pkg.
module nec_ir_cfg_regs
  import nec_ir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TIME_W-1:0]    wr_data,
  output windows_t             windows
);

  always_ff @(posedge clk) begin
    if (rst) begin
      windows.leader_min <= LEADER_MIN_RST;
      windows.leader_max <= LEADER_MAX_RST;
      windows.zero_min   <= ZERO_MIN_RST;
      windows.zero_max   <= ZERO_MAX_RST;
      windows.one_min    <= ONE_MIN_RST;
      windows.one_max    <= ONE_MAX_RST;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_LEADER_MIN: windows.leader_min <= wr_data;
        CFG_LEADER_MAX: windows.leader_max <= wr_data;
        CFG_ZERO_MIN:   windows.zero_min   <= wr_data;
        CFG_ZERO_MAX:   windows.zero_max   <= wr_data;
        CFG_ONE_MIN:    windows.one_min    <= wr_data;
        CFG_ONE_MAX:    windows.one_max    <= wr_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

FILE: rtl/nec_ir_frame.sv
// Frame state and per-edge decode: interval, window match, bit shift and count.
// Depends on nec_ir_pkg.
module nec_ir_frame
  import nec_ir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  windows_t          windows,
  input  logic [TIME_W-1:0] edge_time,
  input  logic              advance,
  output frame_result_t     result
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

  logic [TIME_W-1:0]     previous_edge;
  logic                  receiving;
  logic [CNT_W-1:0]      bits_left;
  logic [FRAME_BITS-1:0] shift_code;

  logic                  receiving_next;
  logic [CNT_W-1:0]      bits_left_next;
  logic [FRAME_BITS-1:0] shift_code_next;

  logic [TIME_W-1:0]     interval;
  logic                  is_leader, is_zero, is_one;
  logic [FRAME_BITS-1:0] shifted;

  assign interval  = edge_time - previous_edge;
  assign is_leader = in_window(interval, windows.leader_min, windows.leader_max);
  assign is_zero   = in_window(interval, windows.zero_min, windows.zero_max);
  assign is_one    = in_window(interval, windows.one_min, windows.one_max);
  assign shifted   = (shift_code << 1) | FRAME_BITS'(!is_zero);

  always_comb begin
    receiving_next  = receiving;
    bits_left_next  = bits_left;
    shift_code_next = shift_code;
    result.done     = 1'b0;
    result.code     = IR_CODE_W'(shifted);
    if (!receiving) begin
      if (is_leader) begin
        receiving_next  = 1'b1;
        bits_left_next  = FRAME_CNT;
        shift_code_next = '0;
      end
    end else if (is_zero || is_one) begin
      if (bits_left == CNT_W'(1)) begin
        // last bit: emit and rearm
        result.done     = 1'b1;
        receiving_next  = 1'b0;
        bits_left_next  = FRAME_CNT;
        shift_code_next = '0;
      end else begin
        bits_left_next  = bits_left - CNT_W'(1);
        shift_code_next = shifted;
      end
    end else begin
      // bad interval: drop the partial frame
      receiving_next  = 1'b0;
      bits_left_next  = FRAME_CNT;
      shift_code_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge <= '0;
      receiving     <= 1'b0;
      bits_left     <= FRAME_CNT;
      shift_code    <= '0;
    end else if (advance) begin
      previous_edge <= edge_time;
      receiving     <= receiving_next;
      bits_left     <= bits_left_next;
      shift_code    <= shift_code_next;
    end
  end

endmodule

FILE: rtl/nec_ir_edge_interval_decoder.sv
// Top level of the NEC infrared edge-interval decoder: input stage, result register.
// Depends on nec_ir_pkg, nec_ir_cfg_regs and nec_ir_frame.
//
// Each request carries a 16-bit free-running microsecond timestamp taken at a
// falling edge of the receiver output. The block measures the interval since the
// previous edge modulo 65536 (the first edge after reset is measured against 0).
// An interval inside the leader window arms reception; after that every interval
// inside the zero window (tested first) or the one window shifts a bit in, first
// bit ending up in the top bit of the frame. After FRAME_BITS bits the frame is
// delivered on ir_code, zero-extended to 32 bits, and the decoder waits for the
// next leader. An interval outside both bit windows while receiving drops the
// partial frame silently; repeat codes fall outside the leader window and are
// ignored. Timing: a request is captured in an input register and decoded by the
// frame logic during the next cycle; if it completes a frame, the code is loaded
// into the output register when the input stage advances, which waits while an
// untaken code is held. One request is taken every cycle; the input stage holds
// a request only when it completes a frame while the output register still holds
// an untaken code. Windows are written through the cfg port (always ready); the
// user must do so only while the block is idle; the block does not enforce it.
module nec_ir_edge_interval_decoder
  import nec_ir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     edge_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IR_CODE_W-1:0]  ir_code
);

  windows_t          windows;
  frame_result_t     result;
  logic              stage_valid;
  logic [TIME_W-1:0] stage_edge;
  logic              stage_fire;

  assign cfg_ready = 1'b1;

  nec_ir_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .windows  (windows)
  );

  nec_ir_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .windows   (windows),
    .edge_time (stage_edge),
    .advance   (stage_fire),
    .result    (result)
  );

  // Advance the staged edge unless it finishes a frame and the output is blocked
  assign stage_fire = stage_valid && (!result.done || !out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_edge <= edge_time;
    end
  end

  // Result register: load a finished frame, drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && result.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && result.done) begin
      ir_code <= result.code;
    end
  end

endmodule

FILE: rtl/nec_ir_checker.sv
// Port-level checker for the NEC infrared edge-interval decoder, with its bind.
// Depends on nec_ir_pkg and the top level nec_ir_edge_interval_decoder.
module nec_ir_checker
  import nec_ir_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IR_CODE_W-1:0] ir_code
);

  // A waiting code holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ir_code))
    else $error("ir_code changed or dropped while stalled");

  // With the output register empty the input side never blocks
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // Reset leaves no code pending
  a_reset_clear: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind nec_ir_edge_interval_decoder nec_ir_checker u_nec_ir_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ir_code   (ir_code)
);

FILE: bench/nec_ir_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the NEC infrared edge-interval decoder: follows window writes,
// predicts every completed frame from the accepted edges and checks delivered codes.
// Depends on nec_ir_pkg.
module nec_ir_frame_checker
  import nec_ir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [TIME_W-1:0]    edge_time,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [IR_CODE_W-1:0] ir_code,
  output int unsigned          mismatches,
  output int unsigned          codes_pending,
  output int unsigned          codes_taken
);

  localparam int unsigned MAX_REPORTS = 40;

  windows_t             win;
  logic [TIME_W-1:0]    last_edge;
  bit                   armed;
  logic [5:0]           bits_to_go;
  logic [IR_CODE_W-1:0] code_acc;
  logic [IR_CODE_W-1:0] code_queue[$];

  function automatic bit in_range(input logic [TIME_W-1:0] v,
                                  input logic [TIME_W-1:0] lo,
                                  input logic [TIME_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic drop_frame();
    armed      = 1'b0;
    code_acc   = '0;
    bits_to_go = 6'(FRAME_BITS);
  endtask

  // Advance the frame state by one edge; queue the code when the frame fills.
  task automatic decode_edge(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] gap;
    bit                is_zero;
    bit                is_one;
    gap       = t - last_edge;
    last_edge = t;
    is_zero   = in_range(gap, win.zero_min, win.zero_max);
    is_one    = in_range(gap, win.one_min, win.one_max);
    if (!armed) begin
      if (in_range(gap, win.leader_min, win.leader_max)) begin
        drop_frame();
        armed = 1'b1;
      end
    end else if (is_zero || is_one) begin
      // zero window wins where the two overlap
      code_acc = {code_acc[IR_CODE_W-2:0], !is_zero};
      if (bits_to_go != 0) bits_to_go--;
      if (bits_to_go == 0) begin
        code_queue.push_back(code_acc);
        drop_frame();
      end
    end else begin
      drop_frame();
    end
  endtask

  always @(posedge clk) begin : track
    logic [IR_CODE_W-1:0] expected;
    if (rst) begin
      win.leader_min = LEADER_MIN_RST;
      win.leader_max = LEADER_MAX_RST;
      win.zero_min   = ZERO_MIN_RST;
      win.zero_max   = ZERO_MAX_RST;
      win.one_min    = ONE_MIN_RST;
      win.one_max    = ONE_MAX_RST;
      last_edge      = '0;
      drop_frame();
      code_queue.delete();
      codes_taken    = 0;
    end else begin
      if (out_valid && out_ready) begin
        codes_taken++;
        if (code_queue.size() == 0) begin
          report_mismatch($sformatf("ir_code %h delivered with no frame outstanding",
                                    ir_code));
        end else begin
          expected = code_queue.pop_front();
          if (ir_code !== expected) begin
            report_mismatch($sformatf("ir_code got %h, expected %h", ir_code, expected));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEADER_MIN: win.leader_min = cfg_data;
          CFG_LEADER_MAX: win.leader_max = cfg_data;
          CFG_ZERO_MIN:   win.zero_min   = cfg_data;
          CFG_ZERO_MAX:   win.zero_max   = cfg_data;
          CFG_ONE_MIN:    win.one_min    = cfg_data;
          CFG_ONE_MAX:    win.one_max    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_edge(edge_time);
    end
    codes_pending = code_queue.size();
  end

endmodule

FILE: bench/nec_ir_edge_interval_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for nec_ir_edge_interval_decoder: generates edge timestamps and
// window writes, plays the code receiver and prints the verdict.
// Depends on nec_ir_pkg, the decoder RTL and nec_ir_frame_checker.
module nec_ir_edge_interval_decoder_tb;
  import nec_ir_pkg::*;

  localparam int unsigned FRAME_BITS    = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned PHASE_EDGES   = 150;
  localparam int unsigned EDGE_TARGET   = 1250;
  localparam int unsigned CODE_TARGET   = 40;
  localparam int unsigned NUM_SETUPS    = 7;
  // index past the last window register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    edge_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IR_CODE_W-1:0] ir_code;

  int unsigned mismatches;
  int unsigned codes_pending;
  int unsigned codes_taken;
  int unsigned edges_sent  = 0;
  int unsigned cycle_count = 0;

  bit                gaps_on   = 1'b1;   // sender inserts idle cycles
  bit                stalls_on = 1'b1;   // receiver drops ready at random
  bit                hold_req  = 1'b0;   // ask the receiver for one long hold-off
  logic [TIME_W-1:0] now_ticks = '0;     // free-running microsecond counter
  windows_t          active;             // windows the stimulus aims at
  windows_t          setups[NUM_SETUPS];

  nec_ir_edge_interval_decoder #(
    .FRAME_BITS(FRAME_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .edge_time(edge_time),
    .out_valid(out_valid), .out_ready(out_ready), .ir_code(ir_code)
  );

  nec_ir_frame_checker #(
    .FRAME_BITS(FRAME_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .edge_time(edge_time),
    .out_valid(out_valid), .out_ready(out_ready), .ir_code(ir_code),
    .mismatches(mismatches), .codes_pending(codes_pending), .codes_taken(codes_taken)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: count cycles and give up on a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Idle lengths: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pick an interval inside [lo, hi], favoring the bounds; anything if the window is empty.
  function automatic logic [TIME_W-1:0] pick_in(input logic [TIME_W-1:0] lo,
                                                input logic [TIME_W-1:0] hi);
    int unsigned r;
    if (lo > hi) return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 20) return lo;
    if (r < 40) return hi;
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic windows_t make_windows(input logic [TIME_W-1:0] lmin, lmax,
                                            input logic [TIME_W-1:0] zmin, zmax,
                                            input logic [TIME_W-1:0] omin, omax);
    windows_t w;
    w.leader_min = lmin;
    w.leader_max = lmax;
    w.zero_min   = zmin;
    w.zero_max   = zmax;
    w.one_min    = omin;
    w.one_max    = omax;
    return w;
  endfunction

  // Receiver: take codes, stall at random, and serve one long hold-off on request.
  initial begin : receiver
    int unsigned r;
    wait (!rst);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && r < 30) begin
        out_ready <= 1'b0;
        repeat (draw_gap() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one edge request and hold it until taken; then maybe idle the input.
  // Valid stays high when no gap follows, so back-to-back requests never toggle it.
  task automatic send_edge(input logic [TIME_W-1:0] t);
    int unsigned g;
    in_valid  <= 1'b1;
    edge_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    edges_sent++;
    g = gaps_on ? draw_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Advance the microsecond counter by one interval (wrapping) and send the edge.
  task automatic step_by(input logic [TIME_W-1:0] interval);
    now_ticks = now_ticks + interval;
    send_edge(now_ticks);
  endtask

  // Leader, then the first nbits of code, MSB first, with intervals from the windows.
  task automatic send_frame(input logic [IR_CODE_W-1:0] code, input int unsigned nbits);
    step_by(pick_in(active.leader_min, active.leader_max));
    for (int i = 0; i < nbits; i++) begin
      if (code[FRAME_BITS-1-i]) step_by(pick_in(active.one_min, active.one_max));
      else step_by(pick_in(active.zero_min, active.zero_max));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_windows(input windows_t w);
    write_reg(CFG_LEADER_MIN, w.leader_min);
    write_reg(CFG_LEADER_MAX, w.leader_max);
    write_reg(CFG_ZERO_MIN, w.zero_min);
    write_reg(CFG_ZERO_MAX, w.zero_max);
    write_reg(CFG_ONE_MIN, w.one_min);
    write_reg(CFG_ONE_MAX, w.one_max);
    if ($urandom_range(0, 1)) write_reg(CFG_SPARE_IDX, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    active = w;
  endtask

  // Drop valid, wait out every outstanding code, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (codes_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random codes; the rest broken frames and stray edges.
  // The closing phase keeps going until enough edges and codes have gone through.
  task automatic random_phase(input bit closing);
    int unsigned first;
    int unsigned r;
    first = edges_sent;
    while ((edges_sent - first < PHASE_EDGES) ||
           (closing && (edges_sent < EDGE_TARGET || codes_taken < CODE_TARGET))) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame($urandom(), FRAME_BITS);
      end else if (r < 85) begin
        send_frame($urandom(), $urandom_range(0, FRAME_BITS - 1));
        step_by(16'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(1, 3)) step_by(16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin : stimulus
    setups[0] = make_windows(LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                             ONE_MIN_RST, ONE_MAX_RST);
    // overlapping bit windows: zero takes the shared intervals
    setups[1] = make_windows(16'd9000, 16'd9500, 16'd500, 16'd1500, 16'd1000, 16'd2000);
    // extremes: every interval is a leader, bits only at 0 and 65535
    setups[2] = make_windows(16'd0, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535);
    // empty zero window, single-point one window
    setups[3] = make_windows(16'd60000, 16'd65535, 16'd5000, 16'd4000, 16'd1, 16'd1);
    // single-point windows everywhere
    setups[4] = make_windows(16'd9000, 16'd9000, 16'd3, 16'd3, 16'd40000, 16'd40000);
    setups[5] = make_windows(16'($urandom_range(20000, 30000)), 16'($urandom_range(30000, 40000)),
                             16'($urandom_range(0, 2000)), 16'($urandom_range(1000, 4000)),
                             16'($urandom_range(3000, 8000)), 16'($urandom_range(6000, 12000)));
    setups[6] = setups[0];
    active    = setups[0];

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed edges at the reset windows.
    step_by(LEADER_MIN_RST);       // first edge, measured from zero: arms
    step_by(16'd13500);            // leader length while receiving: drop the frame
    step_by(16'd5);                // stray while waiting: ignore
    step_by(16'd39030);            // lands on 65535
    step_by(16'd1);                // wraps to 0
    step_by(LEADER_MIN_RST);       // arm at the leader floor
    step_by(ZERO_MAX_RST);
    step_by(ZERO_MIN_RST);
    step_by(ONE_MIN_RST);
    step_by(ONE_MAX_RST);
    step_by(16'd1);                // too short: drop
    step_by(LEADER_MAX_RST);       // arm at the leader ceiling
    step_by(ONE_MAX_RST + 16'd1);  // just past one window: drop
    step_by(LEADER_MIN_RST - 16'd1);
    step_by(LEADER_MAX_RST + 16'd1);
    step_by(LEADER_MIN_RST + 16'd500);
    step_by(ZERO_MAX_RST + 16'd1); // between the bit windows: drop
    step_by(LEADER_MAX_RST);
    step_by(ZERO_MIN_RST - 16'd1); // just below zero window: drop
    step_by(LEADER_MIN_RST);
    step_by(ONE_MIN_RST - 16'd1);  // just below one window: drop

    for (int p = 0; p < NUM_SETUPS; p++) begin
      settle();
      apply_windows(setups[p]);
      stalls_on = (p % 3 != 1);
      if (p == NUM_SETUPS - 1) begin
        // Hold the receiver off while full frames pour in, so the block backs up,
        // then pause until every code has drained.
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (4) send_frame($urandom(), FRAME_BITS);
        settle();
      end
      random_phase(p == NUM_SETUPS - 1);
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
